@@ rtl/psu_pkg.sv @@
// Shared sizes and controller/datapath interface types for the prime-sum block.
package psu_pkg;

  localparam int LIMIT_WIDTH = 12;
  localparam int SUM_WIDTH   = 22;
  // Divisor never passes floor(sqrt(limit)) + 1.
  localparam int DIV_W       = LIMIT_WIDTH / 2 + 2;
  localparam int SQ_W        = LIMIT_WIDTH + 2;
  localparam int CAND_W      = LIMIT_WIDTH + 1;
  localparam int BIT_W       = $clog2(LIMIT_WIDTH);

  typedef struct packed {
    logic load;        // capture limit, restart candidate and sum
    logic start_cand;  // divisor back to two
    logic start_mod;   // clear remainder, point at top dividend bit
    logic mod_step;    // one restoring remainder step
    logic next_div;    // advance divisor and its square
    logic add_sum;     // add candidate to running sum
    logic next_cand;   // advance candidate
    logic out_load;    // move sum into output register
  } psu_cmd_t;

  typedef struct packed {
    logic cand_gt_lim;
    logic sq_gt_cand;
    logic rem_zero;
    logic bit_last;
  } psu_stat_t;

endpackage

@@ rtl/psu_dpath.sv @@
// Datapath: candidate and divisor counters, bit-serial remainder, sum and output registers.
module psu_dpath
  import psu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  psu_cmd_t               cmd,
  input  logic [LIMIT_WIDTH-1:0] in_limit,
  output psu_stat_t              stat,
  output logic [SUM_WIDTH-1:0]   out_prime_sum
);

  logic [LIMIT_WIDTH-1:0] lim_r,  lim_nxt;
  logic [CAND_W-1:0]      cand_r, cand_nxt;
  logic [DIV_W-1:0]       div_r,  div_nxt;
  logic [SQ_W-1:0]        sq_r,   sq_nxt;
  logic [DIV_W-1:0]       rem_r,  rem_nxt;
  logic [BIT_W-1:0]       bit_r,  bit_nxt;
  logic [SUM_WIDTH-1:0]   sum_r,  sum_nxt;
  logic [SUM_WIDTH-1:0]   prime_sum_r, prime_sum_nxt;
  logic [DIV_W:0]         shifted;

  assign shifted = {rem_r, cand_r[bit_r]};

  always_comb begin
    lim_nxt       = lim_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    sum_nxt       = sum_r;
    prime_sum_nxt = prime_sum_r;
    if (cmd.load) begin
      lim_nxt  = in_limit;
      cand_nxt = CAND_W'(2);
      sum_nxt  = '0;
    end
    if (cmd.start_cand) begin
      div_nxt = DIV_W'(2);
      sq_nxt  = SQ_W'(4);
    end
    if (cmd.start_mod) begin
      rem_nxt = '0;
      bit_nxt = BIT_W'(LIMIT_WIDTH - 1);
    end
    if (cmd.mod_step) begin
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(shifted - {1'b0, div_r});
      end else begin
        rem_nxt = DIV_W'(shifted);
      end
      bit_nxt = bit_r - BIT_W'(1);
    end
    if (cmd.next_div) begin
      div_nxt = div_r + DIV_W'(1);
      sq_nxt  = sq_r + SQ_W'({div_r, 1'b0}) + SQ_W'(1);
    end
    if (cmd.add_sum) begin
      sum_nxt = sum_r + SUM_WIDTH'(cand_r);
    end
    if (cmd.next_cand) begin
      cand_nxt = cand_r + CAND_W'(1);
    end
    if (cmd.out_load) begin
      prime_sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    cand_r      <= cand_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    sum_r       <= sum_nxt;
    prime_sum_r <= prime_sum_nxt;
  end

  assign stat.cand_gt_lim = cand_r > {1'b0, lim_r};
  assign stat.sq_gt_cand  = sq_r > SQ_W'(cand_r);
  assign stat.rem_zero    = (rem_r == '0);
  assign stat.bit_last    = (bit_r == '0);
  assign out_prime_sum    = prime_sum_r;

  a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cand_r == CAND_W'(2)) && (sum_r == '0))
    else $error("candidate or sum not restarted on load");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |=> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_mod |-> (div_r >= DIV_W'(2)) &&
                      (sq_r == SQ_W'(div_r) * SQ_W'(div_r)))
    else $error("divisor square out of step");

endmodule

@@ rtl/psu_ctrl.sv @@
// Controller: sequences candidates, divisors and remainder steps; owns the output valid.
module psu_ctrl
  import psu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  psu_stat_t stat,
  output psu_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_TEST,
    S_MOD,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        if (stat.cand_gt_lim) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.start_cand = 1'b1;
          state_nxt      = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.sq_gt_cand) begin
          cmd.add_sum   = 1'b1;
          cmd.next_cand = 1'b1;
          state_nxt     = S_CAND;
        end else begin
          cmd.start_mod = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.bit_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.rem_zero) begin
          cmd.next_cand = 1'b1;
          state_nxt     = S_CAND;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_TEST;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> slot_free)
    else $error("output word overwritten before taken");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after taking a word");

  a_finish_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=>
      (state_r == S_FINISH && out_valid_r))
    else $error("finish left while output slot busy");

endmodule

@@ rtl/prime_sum_upto.sv @@
// Top level: sum of all primes not above a limit, by trial division.
//
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_limit   | inclusive upper bound (12 b)
//  out     | out_valid, out_ready,          | sum of primes <= limit (22 b)
//          | out_prime_sum                  |
//
// Operation: after a limit is taken, each candidate from 2 to the limit is
//   tested against trial divisors d with d*d <= candidate, stopping at the
//   first exact divisor, in the bit-serial remainder loop; a candidate with no
//   exact divisor is added to the sum. A limit below 2 gives a sum of zero.
// One word is in flight at a time; in_ready is high only while idle.
// The finished sum sits in an output register, so a new limit is taken as
//   soon as the sum is loaded there, even if out_ready is still low.
// A stalled output holds the engine in its finish step until the slot frees.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
//   out_valid; datapath registers are loaded before use and need no reset.
module prime_sum_upto
  import psu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [LIMIT_WIDTH-1:0] in_limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SUM_WIDTH-1:0]   out_prime_sum
);

  psu_cmd_t  cmd;
  psu_stat_t stat;

  // Sequencer: walks candidates, divisors and remainder bits.
  psu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Counters, remainder unit, accumulator and output word.
  psu_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_limit      (in_limit),
    .stat          (stat),
    .out_prime_sum (out_prime_sum)
  );

endmodule
